/* hdl/assert_macros.svh */
// Assertion helpers; expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond holds, so prop holds in the same cycle
`define ASSERT_SAME(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// cond holds, so prop holds in the next cycle
`define ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

/* hdl/gcdl_pkg.sv */
package gcdl_pkg;

    localparam int STEP_W = 4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDEFINED = 2'd2;

    localparam logic FUNC_GCD = 1'b0;

    typedef logic [STEP_W-1:0] step_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_DIV_UV,
        OP_SWAP,
        OP_DIV_BG,
        OP_MUL,
        OP_OUT_GCD,
        OP_OUT_LCM,
        OP_OUT_UNDEF
    } op_t;

    typedef enum logic [2:0] {
        C_NEXT,
        C_ALWAYS,
        C_NO_START,
        C_V_ZERO,
        C_U_ZERO,
        C_FUNC_GCD,
        C_DIV_BUSY,
        C_MUL_BUSY
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } ctrl_word_t;

    typedef struct packed {
        logic start;
        logic v_zero;
        logic u_zero;
        logic func_gcd;
        logic div_busy;
        logic mul_busy;
    } flags_t;

    localparam step_t STEP_IDLE      = 4'd0;
    localparam step_t STEP_TEST      = 4'd1;
    localparam step_t STEP_DIV_UV    = 4'd2;
    localparam step_t STEP_WAIT_UV   = 4'd3;
    localparam step_t STEP_SWAP      = 4'd4;
    localparam step_t STEP_SELECT    = 4'd5;
    localparam step_t STEP_CHK_ZERO  = 4'd6;
    localparam step_t STEP_DIV_BG    = 4'd7;
    localparam step_t STEP_WAIT_BG   = 4'd8;
    localparam step_t STEP_MUL       = 4'd9;
    localparam step_t STEP_WAIT_MUL  = 4'd10;
    localparam step_t STEP_OUT_LCM   = 4'd11;
    localparam step_t STEP_OUT_GCD   = 4'd12;
    localparam step_t STEP_OUT_UNDEF = 4'd13;

    // Microprogram: Euclid loop, then b / gcd and a * quotient for LCM.
    function automatic ctrl_word_t control_rom(input step_t step);
        ctrl_word_t w;
        begin
            w = '{op: OP_NOP, cond: C_ALWAYS, target: STEP_IDLE};
            unique case (step)
                STEP_IDLE:      w = '{op: OP_LOAD,      cond: C_NO_START, target: STEP_IDLE};
                STEP_TEST:      w = '{op: OP_NOP,       cond: C_V_ZERO,   target: STEP_SELECT};
                STEP_DIV_UV:    w = '{op: OP_DIV_UV,    cond: C_NEXT,     target: STEP_IDLE};
                STEP_WAIT_UV:   w = '{op: OP_NOP,       cond: C_DIV_BUSY, target: STEP_WAIT_UV};
                STEP_SWAP:      w = '{op: OP_SWAP,      cond: C_ALWAYS,   target: STEP_TEST};
                STEP_SELECT:    w = '{op: OP_NOP,       cond: C_FUNC_GCD, target: STEP_OUT_GCD};
                STEP_CHK_ZERO:  w = '{op: OP_NOP,       cond: C_U_ZERO,   target: STEP_OUT_UNDEF};
                STEP_DIV_BG:    w = '{op: OP_DIV_BG,    cond: C_NEXT,     target: STEP_IDLE};
                STEP_WAIT_BG:   w = '{op: OP_NOP,       cond: C_DIV_BUSY, target: STEP_WAIT_BG};
                STEP_MUL:       w = '{op: OP_MUL,       cond: C_NEXT,     target: STEP_IDLE};
                STEP_WAIT_MUL:  w = '{op: OP_NOP,       cond: C_MUL_BUSY, target: STEP_WAIT_MUL};
                STEP_OUT_LCM:   w = '{op: OP_OUT_LCM,   cond: C_ALWAYS,   target: STEP_IDLE};
                STEP_OUT_GCD:   w = '{op: OP_OUT_GCD,   cond: C_ALWAYS,   target: STEP_IDLE};
                STEP_OUT_UNDEF: w = '{op: OP_OUT_UNDEF, cond: C_ALWAYS,   target: STEP_IDLE};
                default:        w = '{op: OP_NOP,       cond: C_ALWAYS,   target: STEP_IDLE};
            endcase
            return w;
        end
    endfunction

endpackage

/* hdl/gcdl_sequencer.sv */
module gcdl_sequencer
    import gcdl_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  flags_t flags,
    output op_t    op,
    output logic   busy
);

    step_t      step_reg;
    step_t      step_next;
    ctrl_word_t word;
    logic       taken;

    assign word = control_rom(step_reg);
    assign op   = word.op;
    assign busy = (step_reg != STEP_IDLE);

    always_comb
    begin
        unique case (word.cond)
            C_NEXT:     taken = 1'b0;
            C_ALWAYS:   taken = 1'b1;
            C_NO_START: taken = !flags.start;
            C_V_ZERO:   taken = flags.v_zero;
            C_U_ZERO:   taken = flags.u_zero;
            C_FUNC_GCD: taken = flags.func_gcd;
            C_DIV_BUSY: taken = flags.div_busy;
            C_MUL_BUSY: taken = flags.mul_busy;
            default:    taken = 1'b0;
        endcase
        step_next = taken ? word.target : step_reg + step_t'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= STEP_IDLE;
        else
            step_reg <= step_next;
    end

endmodule

/* hdl/gcdl_divider.sv */
// Restoring divider, one quotient bit per cycle.
module gcdl_divider #(
    parameter int WIDTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [WIDTH-1:0] dividend,
    input  logic [WIDTH-1:0] divisor,
    output logic             busy,
    output logic [WIDTH-1:0] quotient,
    output logic [WIDTH-1:0] remainder
);

    localparam int CNT_W = $clog2(WIDTH + 1);

    logic [CNT_W-1:0] count_reg;
    logic             busy_reg;
    logic [WIDTH-1:0] rem_reg;
    logic [WIDTH-1:0] quo_reg;
    logic [WIDTH-1:0] dsr_reg;
    logic [WIDTH:0]   shifted;
    logic [WIDTH:0]   diff;

    assign shifted   = {rem_reg, quo_reg[WIDTH-1]};
    assign diff      = shifted - {1'b0, dsr_reg};
    assign busy      = busy_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
        end
        else if (start)
        begin
            busy_reg  <= 1'b1;
            count_reg <= CNT_W'(WIDTH);
        end
        else if (busy_reg)
        begin
            count_reg <= count_reg - CNT_W'(1);
            if (count_reg == CNT_W'(1))
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            // diff is negative when the trial subtract does not fit
            if (!diff[WIDTH])
            begin
                rem_reg <= diff[WIDTH-1:0];
                quo_reg <= {quo_reg[WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[WIDTH-1:0];
                quo_reg <= {quo_reg[WIDTH-2:0], 1'b0};
            end
        end
    end

endmodule

/* hdl/gcdl_multiplier.sv */
// Shift-add multiplier, one multiplier bit per cycle.
module gcdl_multiplier #(
    parameter int WIDTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [WIDTH-1:0] multiplicand,
    input  logic [WIDTH-1:0] multiplier,
    output logic             busy,
    output logic [WIDTH-1:0] product,
    output logic             overflow
);

    localparam int CNT_W = $clog2(WIDTH + 1);

    logic [CNT_W-1:0] count_reg;
    logic             busy_reg;
    logic [WIDTH-1:0] mcand_reg;
    logic [WIDTH-1:0] hi_reg;
    logic [WIDTH-1:0] lo_reg;
    logic [WIDTH:0]   sum;

    assign sum      = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, mcand_reg} : '0);
    assign busy     = busy_reg;
    assign product  = lo_reg;
    assign overflow = (hi_reg != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
        end
        else if (start)
        begin
            busy_reg  <= 1'b1;
            count_reg <= CNT_W'(WIDTH);
        end
        else if (busy_reg)
        begin
            count_reg <= count_reg - CNT_W'(1);
            if (count_reg == CNT_W'(1))
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mcand_reg <= multiplicand;
            hi_reg    <= '0;
            lo_reg    <= multiplier;
        end
        else if (busy_reg)
        begin
            hi_reg <= sum[WIDTH:1];
            lo_reg <= {sum[0], lo_reg[WIDTH-1:1]};
        end
    end

endmodule

/* hdl/integer_gcd_lcm_unit.sv */
// GCD / LCM of two signed integers, one request at a time.
// Request: func, first_operand, second_operand are taken at a clock edge
// with start high and busy low. busy stays high until the result is out.
// Result: result_value and status are valid for exactly one cycle while
// done is high; the receiver cannot stall, so nothing is held back.
// Operands are cut or sign-extended to WIDTH bits and their magnitudes used.
// The Euclid loop runs one bit-serial divide per iteration (data dependent,
// about 1.44*WIDTH iterations worst case); an LCM then adds the b/gcd
// divide and the multiply, unless both operands are zero. The next request
// is taken in the cycle done is high.
// Control runs from a microprogram table with a step counter.
// Reset: asynchronous, active low; returns to idle with done low.
module integer_gcd_lcm_unit
    import gcdl_pkg::*;
#(
    parameter int WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        func,
    input  logic [31:0] first_operand,
    input  logic [31:0] second_operand,
    output logic        done,
    output logic [31:0] result_value,
    output logic [1:0]  status
);

    op_t              op;
    flags_t           flags;
    logic [WIDTH-1:0] first_w;
    logic [WIDTH-1:0] second_w;
    logic [WIDTH-1:0] first_mag;
    logic [WIDTH-1:0] second_mag;
    logic [WIDTH-1:0] u_reg;
    logic [WIDTH-1:0] v_reg;
    logic [WIDTH-1:0] a_reg;
    logic [WIDTH-1:0] b_reg;
    logic             func_reg;
    logic             div_start;
    logic             div_busy;
    logic [WIDTH-1:0] div_dividend;
    logic [WIDTH-1:0] div_divisor;
    logic [WIDTH-1:0] div_quotient;
    logic [WIDTH-1:0] div_remainder;
    logic             mul_start;
    logic             mul_busy;
    logic [WIDTH-1:0] mul_product;
    logic             mul_overflow;
    logic [31:0]      u_fit;
    logic [31:0]      prod_fit;
    logic [31:0]      max_fit;
    logic             done_reg;
    logic [31:0]      result_value_reg;
    logic [1:0]       status_reg;

    generate
        if (WIDTH >= 32)
        begin : g_wide
            assign first_w  = {{(WIDTH-32){first_operand[31]}}, first_operand};
            assign second_w = {{(WIDTH-32){second_operand[31]}}, second_operand};
            assign u_fit    = u_reg[31:0];
            assign prod_fit = mul_product[31:0];
            assign max_fit  = '1;
        end
        else
        begin : g_narrow
            assign first_w  = first_operand[WIDTH-1:0];
            assign second_w = second_operand[WIDTH-1:0];
            assign u_fit    = {{(32-WIDTH){1'b0}}, u_reg};
            assign prod_fit = {{(32-WIDTH){1'b0}}, mul_product};
            assign max_fit  = {{(32-WIDTH){1'b0}}, {WIDTH{1'b1}}};
        end
    endgenerate

    assign first_mag  = first_w[WIDTH-1] ? (~first_w + WIDTH'(1)) : first_w;
    assign second_mag = second_w[WIDTH-1] ? (~second_w + WIDTH'(1)) : second_w;

    assign flags = '{start:    start,
                     v_zero:   (v_reg == '0),
                     u_zero:   (u_reg == '0),
                     func_gcd: (func_reg == FUNC_GCD),
                     div_busy: div_busy,
                     mul_busy: mul_busy};

    gcdl_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .op    (op),
        .busy  (busy)
    );

    // LCM step divides b by the gcd left in u
    assign div_start    = (op == OP_DIV_UV) || (op == OP_DIV_BG);
    assign div_dividend = (op == OP_DIV_BG) ? b_reg : u_reg;
    assign div_divisor  = (op == OP_DIV_BG) ? u_reg : v_reg;

    gcdl_divider #(.WIDTH(WIDTH)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .busy      (div_busy),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

    assign mul_start = (op == OP_MUL);

    gcdl_multiplier #(.WIDTH(WIDTH)) u_mul (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (mul_start),
        .multiplicand (a_reg),
        .multiplier   (div_quotient),
        .busy         (mul_busy),
        .product      (mul_product),
        .overflow     (mul_overflow)
    );

    always_ff @(posedge clk)
    begin
        case (op)
            OP_LOAD:
            begin
                a_reg    <= first_mag;
                b_reg    <= second_mag;
                u_reg    <= first_mag;
                v_reg    <= second_mag;
                func_reg <= func;
            end
            OP_SWAP:
            begin
                u_reg <= v_reg;
                v_reg <= div_remainder;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= (op == OP_OUT_GCD) || (op == OP_OUT_LCM) || (op == OP_OUT_UNDEF);
    end

    always_ff @(posedge clk)
    begin
        case (op)
            OP_OUT_GCD:
            begin
                result_value_reg <= u_fit;
                status_reg       <= ST_OK;
            end
            OP_OUT_LCM:
            begin
                result_value_reg <= mul_overflow ? max_fit : prod_fit;
                status_reg       <= mul_overflow ? ST_OVERFLOW : ST_OK;
            end
            OP_OUT_UNDEF:
            begin
                result_value_reg <= '0;
                status_reg       <= ST_UNDEFINED;
            end
            default:
            begin
            end
        endcase
    end

    assign done         = done_reg;
    assign result_value = result_value_reg;
    assign status       = status_reg;

endmodule

/* hdl/gcdl_checker.sv */
`include "assert_macros.svh"

module gcdl_checker
    import gcdl_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [31:0] result_value,
    input logic [1:0]  status
);

    // a taken request keeps the unit busy for at least the next cycle
    `ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy low after accepted request")
    `ASSERT_NEXT(a_idle_stays, !start && !busy, !busy && !done, "unit left idle by itself")
    `ASSERT_NEXT(a_done_pulse, done, !done, "done held longer than one cycle")
    `ASSERT_SAME(a_undef_zero, done && (status == ST_UNDEFINED), result_value == '0, "undefined lcm not zero")

endmodule

bind integer_gcd_lcm_unit gcdl_checker u_gcdl_checker (.*);

/* tb/tb_integer_gcd_lcm_unit.sv */
module tb_integer_gcd_lcm_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import gcdl_pkg::*;

    localparam int W = 32;
    localparam logic FUNC_LCM = ~FUNC_GCD;
    localparam int N_RANDOM = 1750;
    localparam int SILENCE_LIMIT = 10000;
    localparam int TAIL_CYCLES = 2000;

    typedef enum int {
        OPND_FULL,
        OPND_SMALL,
        OPND_MULTIPLE,
        OPND_CORNER,
        OPND_POW2
    } operand_kind_t;

    typedef struct {
        logic        func;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] value;
        logic [1:0]  status;
    } gcd_lcm_answer_t;

    class gcd_lcm_scoreboard;
        gcd_lcm_answer_t pending_answers[$];
        int errors;
        int n_gcd;
        int n_lcm;
        int n_saturated;
        int n_undefined;

        // sign-extend from 32 bits, cut to W bits, take |x| of the W-bit signed value
        function logic [63:0] operand_magnitude(logic [31:0] field);
            logic [63:0] mask;
            logic [63:0] v;
            mask = (64'd1 << W) - 64'd1;
            v = {{32{field[31]}}, field} & mask;
            if (v[W-1])
                v = (64'd0 - v) & mask;
            return v;
        endfunction

        function logic [63:0] euclid_gcd(logic [63:0] u, logic [63:0] v);
            logic [63:0] r;
            while (v != 64'd0)
            begin
                r = u % v;
                u = v;
                v = r;
            end
            return u;
        endfunction

        function void note_request(logic f, logic [31:0] a, logic [31:0] b);
            gcd_lcm_answer_t ans;
            logic [63:0] ma;
            logic [63:0] mb;
            logic [63:0] g;
            logic [63:0] q;
            logic [63:0] limit;
            logic [63:0] v;
            ma = operand_magnitude(a);
            mb = operand_magnitude(b);
            g = euclid_gcd(ma, mb);
            limit = (64'd1 << W) - 64'd1;
            ans.func = f;
            ans.a = a;
            ans.b = b;
            ans.status = ST_OK;
            v = 64'd0;
            if (f == FUNC_GCD)
            begin
                v = g;
                n_gcd++;
            end
            else
            begin
                n_lcm++;
                if (g == 64'd0)
                begin
                    v = 64'd0;
                    ans.status = ST_UNDEFINED;
                end
                else
                begin
                    q = mb / g;
                    if (ma != 64'd0 && q > limit / ma)
                    begin
                        v = limit;
                        ans.status = ST_OVERFLOW;
                    end
                    else
                        v = ma * q;
                end
            end
            ans.value = v[31:0];
            pending_answers.push_back(ans);
        endfunction

        function void check_result(logic [31:0] value, logic [1:0] st);
            gcd_lcm_answer_t ans;
            if (pending_answers.size() == 0)
            begin
                $error("result with no request outstanding: result_value %0d status %0d",
                       value, st);
                errors++;
                return;
            end
            ans = pending_answers.pop_front();
            if (ans.status == ST_OVERFLOW)
                n_saturated++;
            if (ans.status == ST_UNDEFINED)
                n_undefined++;
            if (value !== ans.value)
            begin
                $error("result_value: expected %0d, actual %0d (func %0d a %0h b %0h)",
                       ans.value, value, ans.func, ans.a, ans.b);
                errors++;
            end
            if (st !== ans.status)
            begin
                $error("status: expected %0d, actual %0d (func %0d a %0h b %0h)",
                       ans.status, st, ans.func, ans.a, ans.b);
                errors++;
            end
        endfunction

        function int pending();
            return pending_answers.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        func;
    logic [31:0] first_operand;
    logic [31:0] second_operand;
    logic        done;
    logic [31:0] result_value;
    logic [1:0]  status;

    gcd_lcm_scoreboard sb;
    int silent_cycles;

    integer_gcd_lcm_unit #(
        .WIDTH(W)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .func(func),
        .first_operand(first_operand),
        .second_operand(second_operand),
        .done(done),
        .result_value(result_value),
        .status(status)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // request/result monitor and watchdog; sees pre-edge values
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start === 1'b1 && busy === 1'b0)
            begin
                sb.note_request(func, first_operand, second_operand);
                silent_cycles = 0;
            end
            else if (done === 1'b1)
                silent_cycles = 0;
            else
                silent_cycles++;
            if (done === 1'b1)
                sb.check_result(result_value, status);
            if (silent_cycles >= SILENCE_LIMIT)
            begin
                $error("no request or result for %0d cycles", silent_cycles);
                $display("FAIL");
                $finish;
            end
        end
    end

    function automatic operand_kind_t pick_kind();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 30)
            return OPND_FULL;
        if (r < 55)
            return OPND_SMALL;
        if (r < 85)
            return OPND_MULTIPLE;
        if (r < 93)
            return OPND_CORNER;
        return OPND_POW2;
    endfunction

    function automatic logic [31:0] pick_operand(operand_kind_t kind, logic [31:0] factor);
        logic [31:0] corners [7];
        logic [31:0] v;
        corners = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                    32'h8000_0000, 32'h8000_0001, 32'h7FFF_FFFE};
        case (kind)
            OPND_FULL:     v = $urandom;
            OPND_SMALL:    v = $urandom_range(0, 255);
            OPND_MULTIPLE: v = factor * $urandom_range(0, 32767);
            OPND_CORNER:   v = corners[$urandom_range(0, 6)];
            default:       v = 32'd1 << $urandom_range(0, 31);
        endcase
        if ((kind == OPND_SMALL || kind == OPND_MULTIPLE || kind == OPND_POW2)
            && $urandom_range(0, 1))
            v = -v;
        return v;
    endfunction

    // called and returns at a falling edge; start is left high for back-to-back requests
    task automatic send_request(input logic f, input logic [31:0] a, input logic [31:0] b,
                                input bit allow_idle);
        int unsigned gap;
        if (allow_idle && $urandom_range(0, 99) < 38)
        begin
            start = 1'b0;
            func = 1'($urandom_range(0, 1));
            first_operand = $urandom;
            second_operand = $urandom;
            if ($urandom_range(0, 1))
            begin
                // let the unit go idle first so the gap lands after done
                do @(posedge clk); while (busy);
                @(negedge clk);
                gap = $urandom_range(1, 8);
            end
            else
                gap = $urandom_range(1, 60);
            repeat (gap) @(negedge clk);
        end
        func = f;
        first_operand = a;
        second_operand = b;
        start = 1'b1;
        do @(posedge clk); while (busy);
        @(negedge clk);
    endtask

    task automatic drain_results();
        start = 1'b0;
        do @(negedge clk); while (sb.pending() != 0);
    endtask

    initial
    begin
        operand_kind_t ka;
        operand_kind_t kb;
        logic [31:0] factor;
        bit allow_idle;

        sb = new();
        silent_cycles = 0;
        rst_n = 1'b0;
        start = 1'b0;
        func = FUNC_GCD;
        first_operand = 32'd0;
        second_operand = 32'd0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // zeros, most negative operand, saturation boundary, worst-case Euclid
        send_request(FUNC_GCD, 32'd0, 32'd0, 1'b1);
        send_request(FUNC_LCM, 32'd0, 32'd0, 1'b1);
        send_request(FUNC_LCM, 32'd0, 32'd5, 1'b1);
        send_request(FUNC_LCM, -32'sd7, 32'd0, 1'b1);
        send_request(FUNC_GCD, 32'd0, -32'sd9, 1'b1);
        send_request(FUNC_GCD, 32'h8000_0000, 32'h8000_0000, 1'b1);
        send_request(FUNC_GCD, 32'h8000_0000, 32'd0, 1'b1);
        send_request(FUNC_LCM, 32'h8000_0000, 32'h8000_0000, 1'b1);
        send_request(FUNC_LCM, 32'h8000_0000, 32'd3, 1'b1);
        send_request(FUNC_LCM, 32'h8000_0000, -32'sd2, 1'b1);
        send_request(FUNC_LCM, 32'h7FFF_FFFF, 32'h7FFF_FFFE, 1'b1);
        send_request(FUNC_LCM, 32'd65535, 32'd65537, 1'b1);
        send_request(FUNC_LCM, 32'd65536, 32'd65537, 1'b1);
        send_request(FUNC_LCM, 32'd65536, -32'sd65536, 1'b1);
        send_request(FUNC_GCD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
        send_request(FUNC_GCD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_request(FUNC_LCM, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1);
        send_request(FUNC_GCD, 32'd1836311903, 32'd1134903170, 1'b1);
        send_request(FUNC_LCM, 32'd1836311903, 32'd1134903170, 1'b1);
        send_request(FUNC_GCD, -32'sd12, 32'd18, 1'b1);
        send_request(FUNC_LCM, -32'sd12, 32'd18, 1'b1);
        send_request(FUNC_LCM, 32'd4, 32'd6, 1'b1);
        send_request(FUNC_GCD, 32'd1, 32'h7FFF_FFFF, 1'b1);
        send_request(FUNC_GCD, -32'sd48, -32'sd180, 1'b1);
        drain_results();

        for (int i = 0; i < N_RANDOM; i++)
        begin
            factor = $urandom_range(1, 65535);
            ka = pick_kind();
            kb = $urandom_range(0, 1) ? ka : pick_kind();
            allow_idle = !(i >= 700 && i < 1100);
            send_request(1'($urandom_range(0, 1)), pick_operand(ka, factor),
                         pick_operand(kb, factor), allow_idle);
            if (i % 250 == 249)
                drain_results();
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.pending() != 0)
        begin
            $error("%0d expected results never came", sb.pending());
            sb.errors++;
        end
        $display("Covered %0d GCD and %0d LCM requests,", sb.n_gcd, sb.n_lcm);
        $display("incl. %0d saturated and %0d undefined LCMs.",
                 sb.n_saturated, sb.n_undefined);
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
